// File: design/ltmm_pkg.sv
`default_nettype none
package ltmm_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 3;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;

  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_COMPUTE    = 2'd2
  } cmd_t;

endpackage
`default_nettype wire

// File: design/ltmm_in_if.sv
`default_nettype none
interface ltmm_in_if;
  import ltmm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         row;
  logic [POS_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink (input valid, command, row, col, value, output ready);
endinterface
`default_nettype wire

// File: design/ltmm_out_if.sv
`default_nettype none
interface ltmm_out_if;
  import ltmm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [DATA_W-1:0] product;
  logic                     saturated;
  logic                     last;

  modport source (output valid, out_row, out_col, product, saturated, last, input ready);
  modport sink (input valid, out_row, out_col, product, saturated, last, output ready);
endinterface
`default_nettype wire

// File: design/ltmm_ram.sv
`default_nettype none
module ltmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/lower_triangular_matrix_multiply.sv
// load beats: one per cycle while idle (in_ch.ready high), no result
// compute beat: entry (i, j) loops READ, MUL, ACC for k = j..i on the shared multiplier,
// entries come out row-major; in_ch.ready stays low until the last entry is handed to the
// output register, and out_ch back-pressure stalls the sequencer at each entry
// reset (synchronous, rst_n low): both stores read as zero via per-entry valid bits,
// matrix_size returns to 8, no result pending
`default_nettype none
module lower_triangular_matrix_multiply #(
  parameter int MAX_SIZE  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ltmm_in_if.sink                       in_ch,
  ltmm_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ltmm_pkg::SIZE_W-1:0]   cfg_wdata
);
  import ltmm_pkg::*;

  localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int ACC_W = 2 * DATA_W + $clog2(MAX_SIZE + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] row_base(input logic [IW-1:0] r);
    logic [2*IW+1:0] p;
    p = (2*IW+2)'(r) * ((2*IW+2)'(r) + 1'b1);
    return AW'(p >> 1);
  endfunction

  state_t                    state_r, state_nxt;
  logic [SIZE_W-1:0]         size_r, size_nxt;
  logic [NW-1:0]             n_r, n_nxt;
  logic [IW-1:0]             i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DEPTH-1:0]          lval_r, lval_nxt, rval_r, rval_nxt;
  logic                      lv_r, lv_nxt, rv_r, rv_nxt;
  logic signed [2*DATA_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]          orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic signed [DATA_W-1:0]  oprod_r, oprod_nxt;
  logic                      osat_r, osat_nxt, olast_r, olast_nxt;

  logic [SIZE_W-1:0]         n_eff;
  logic                      in_fire, ld_ok, we_l, we_r, rd_en;
  logic [AW-1:0]             ld_addr, raddr_l, raddr_r;
  logic [DATA_W-1:0]         rdata_l, rdata_r;
  logic signed [DATA_W-1:0]  a_op, b_op;
  logic signed [ACC_W-1:0]   sh;
  logic                      sat_hi, sat_lo, row_end, diag, fin_go;

  assign n_eff = (size_r == '0) ? SIZE_W'(1) :
                 (size_r > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ld_ok       = (in_ch.col <= in_ch.row) && (SIZE_W'(in_ch.row) < n_eff);
  assign ld_addr     = row_base(IW'(in_ch.row)) + AW'(in_ch.col);
  assign we_l        = in_fire && (in_ch.command == CMD_LOAD_LEFT) && ld_ok;
  assign we_r        = in_fire && (in_ch.command == CMD_LOAD_RIGHT) && ld_ok;

  assign raddr_l = row_base(i_r) + AW'(k_r);
  assign raddr_r = row_base(k_r) + AW'(j_r);
  assign rd_en   = (state_r == ST_READ);

  ltmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_left (
    .clk   (clk),
    .we    (we_l),
    .waddr (ld_addr),
    .wdata (in_ch.value),
    .re    (rd_en),
    .raddr (raddr_l),
    .rdata (rdata_l)
  );

  ltmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_right (
    .clk   (clk),
    .we    (we_r),
    .waddr (ld_addr),
    .wdata (in_ch.value),
    .re    (rd_en),
    .raddr (raddr_r),
    .rdata (rdata_r)
  );

  // never-written entries read as zero
  assign a_op = lv_r ? signed'(rdata_l) : '0;
  assign b_op = rv_r ? signed'(rdata_r) : '0;

  assign sh     = acc_r >>> FRAC_BITS;
  assign sat_hi = !sh[ACC_W-1] && (|sh[ACC_W-2:DATA_W-1]);
  assign sat_lo = sh[ACC_W-1] && !(&sh[ACC_W-2:DATA_W-1]);

  assign row_end = (({1'b0, i_r} + 1'b1) == (IW+1)'(n_r));
  assign diag    = (j_r == i_r);
  assign fin_go  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = cfg_we ? cfg_wdata : size_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    lval_nxt      = lval_r;
    rval_nxt      = rval_r;
    lv_nxt        = lv_r;
    rv_nxt        = rv_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    oprod_nxt     = oprod_r;
    osat_nxt      = osat_r;
    olast_nxt     = olast_r;

    if (we_l) begin
      lval_nxt[ld_addr] = 1'b1;
    end
    if (we_r) begin
      rval_nxt[ld_addr] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.command == CMD_COMPUTE)) begin
          n_nxt     = NW'(n_eff);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        lv_nxt    = lval_r[raddr_l];
        rv_nxt    = rval_r[raddr_r];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = a_op * b_op;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_r + {{(ACC_W-2*DATA_W){prod_r[2*DATA_W-1]}}, prod_r};
        if (k_r == i_r) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          orow_nxt      = POS_W'(i_r);
          ocol_nxt      = POS_W'(j_r);
          oprod_nxt     = sat_hi ? {1'b0, {(DATA_W-1){1'b1}}} :
                          sat_lo ? {1'b1, {(DATA_W-1){1'b0}}} : sh[DATA_W-1:0];
          osat_nxt      = sat_hi || sat_lo;
          olast_nxt     = row_end && diag;
          acc_nxt       = '0;
          if (diag) begin
            if (row_end) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = i_r + 1'b1;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_READ;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            k_nxt     = j_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RST;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      lval_r      <= '0;
      rval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      lval_r      <= lval_nxt;
      rval_r      <= rval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r    <= lv_nxt;
    rv_r    <= rv_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    oprod_r <= oprod_nxt;
    osat_r  <= osat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = orow_r;
  assign out_ch.out_col   = ocol_r;
  assign out_ch.product   = oprod_r;
  assign out_ch.saturated = osat_r;
  assign out_ch.last      = olast_r;

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (k_r >= j_r && k_r <= i_r))
    else $error("k index outside j..i during accumulate");

  a_row_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ({1'b0, i_r} < (IW+1)'(n_r)))
    else $error("row index beyond matrix order");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fin_go && row_end && diag) |=>
      (state_r == ST_IDLE && out_ch.valid && out_ch.last))
    else $error("final entry did not end the compute");

endmodule
`default_nettype wire
